/* rtl/avps_pkg.sv */
package avps_pkg;

  // Queue geometry and field widths
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int TIME_W      = 48;
  localparam int TAG_W       = 16;
  localparam int ENTRY_W     = TIME_W + TAG_W;
  localparam int LAT_W       = TIME_W + 1;
  localparam int BUF_W       = 10;
  localparam int ADV_W       = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_WINDOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EARLY_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_MIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_MAX    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_STEP   = 3'd6;

  // Reset values
  localparam logic [15:0]      EXPIRY_WINDOW_RST = 16'd5000;
  localparam logic [15:0]      EARLY_LIMIT_RST   = 16'd1000;
  localparam logic [CNT_W-1:0] HIGH_MARK_RST     = 5'd10;
  localparam logic [CNT_W-1:0] LOW_MARK_RST      = 5'd3;
  localparam logic [BUF_W-1:0] BUFFER_MIN_RST    = 10'd50;
  localparam logic [BUF_W-1:0] BUFFER_MAX_RST    = 10'd500;
  localparam logic [7:0]       BUFFER_STEP_RST   = 8'd10;
  localparam logic [BUF_W-1:0] BUFFER_TIME_RST   = 10'd150;

  typedef enum logic [2:0] {
    OP_AUDIO = 3'd0,
    OP_VIDEO = 3'd1,
    OP_TICK  = 3'd2,
    OP_START = 3'd3,
    OP_STOP  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_AUDIO = 2'd0,
    KIND_VIDEO = 2'd1,
    KIND_NONE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    EV_PLAY     = 3'd0,
    EV_DROP     = 3'd1,
    EV_EXPIRED  = 3'd2,
    EV_REJECT   = 3'd3,
    EV_ACCEPTED = 3'd4,
    EV_TICK     = 3'd5,
    EV_CONTROL  = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_CLK,
    S_EXP,
    S_SETTLE,
    S_SERVE,
    S_ADJ,
    S_EMIT
  } state_e;

endpackage

/* rtl/av_playout_sync_buffer_core.sv */
// Audio/video playout jitter buffer.
// Input channel (in_valid_i/in_ready_o) takes one command beat: an audio or
// video frame tag with its timestamp, a clock tick, start or stop. Each beat
// yields one or more result beats on the output channel (out_valid_o /
// out_ready_i); last_o marks the final one. Opcodes 5 to 7 yield nothing.
// Both queues live in one-read, one-write synchronous RAMs addressed by the
// next head pointer, so each head reaches the read register with its pointer.
// Start, stop and a tick while stopped go straight to the result; a frame
// first expires stale heads one at a time, then is rejected or enqueued,
// and an enqueue passes a settle state that lets the written head reach the
// read register. A running tick plays due heads and drops heads too far
// ahead, audio first, then adjusts the buffer time. The next command is
// taken once the last result beat of the current one enters the output
// register.
// The output register holds a finished beat while the next command is taken;
// when the receiver stalls, the block holds at its next result.
// Configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is written on a clock edge with cfg_we_i high.
// Reset empties both queues, clears origin, elapsed time and run state, sets
// the buffer time to 150 ms and loads the register defaults.
module av_playout_sync_buffer_core
  import avps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            opcode_i,
  input  logic [TIME_W-1:0]     frame_time_i,
  input  logic [TAG_W-1:0]      frame_tag_i,
  input  logic [ADV_W-1:0]      advance_ms_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            stream_kind_o,
  output logic [2:0]            event_code_o,
  output logic [TAG_W-1:0]      out_tag_o,
  output logic [TIME_W-1:0]     out_time_o,
  output logic [BUF_W-1:0]      buffer_time_ms_o,
  output logic signed [LAT_W-1:0] latency_ms_o,
  output logic [CNT_W-1:0]      audio_count_o,
  output logic [CNT_W-1:0]      video_count_o,
  output logic                  last_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // configuration registers
  logic [15:0]      expiry_q, early_q;
  logic [CNT_W-1:0] high_q, low_q;
  logic [BUF_W-1:0] bmin_q, bmax_q;
  logic [7:0]       bstep_q;

  // control state
  state_e              state_q, state_d, ret_q, ret_d;
  logic [PTR_W-1:0]    head_q [2];
  logic [PTR_W-1:0]    head_d [2];
  logic [CNT_W-1:0]    cnt_q  [2];
  logic [CNT_W-1:0]    cnt_d  [2];
  logic                seen_q, seen_d, run_q, run_d;
  logic [TIME_W-1:0]   origin_q, origin_d, elapsed_q, elapsed_d, clk_q, clk_d;
  logic [BUF_W-1:0]    buf_q, buf_d;
  logic                k_q, k_d;

  // latched command
  op_e                 op_q;
  logic [TIME_W-1:0]   time_q;
  logic [TAG_W-1:0]    tag_q;
  logic [ADV_W-1:0]    adv_q;

  // pending result
  kind_e               pkind_q, pkind_d;
  event_e              pev_q, pev_d;
  logic [TAG_W-1:0]    ptag_q, ptag_d;
  logic [TIME_W-1:0]   ptime_q, ptime_d;
  logic                plast_q, plast_d;

  // output register
  logic                ovalid_q;
  logic                oload;
  kind_e               okind_q;
  event_e              oev_q;
  logic [TAG_W-1:0]    otag_q;
  logic [TIME_W-1:0]   otime_q;
  logic [BUF_W-1:0]    obuf_q;
  logic signed [LAT_W-1:0] olat_q, lat_now;
  logic [CNT_W-1:0]    oacnt_q, ovcnt_q;
  logic                olast_q;

  // queue memories
  logic [ENTRY_W-1:0]  mem_a [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]  mem_v [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]  rd_q  [2];
  logic                wr_en, wr_k;
  logic [PTR_W-1:0]    wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  // current queue view
  logic                cur_k;
  logic [TIME_W-1:0]   ht;
  logic [TAG_W-1:0]    hg;
  logic [CNT_W-1:0]    ccnt;
  logic [PTR_W-1:0]    chead, hinc, tail;
  logic [CNT_W:0]      tsum;
  logic                out_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !ovalid_q || out_ready_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= EXPIRY_WINDOW_RST;
      early_q  <= EARLY_LIMIT_RST;
      high_q   <= HIGH_MARK_RST;
      low_q    <= LOW_MARK_RST;
      bmin_q   <= BUFFER_MIN_RST;
      bmax_q   <= BUFFER_MAX_RST;
      bstep_q  <= BUFFER_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPIRY_WINDOW: expiry_q <= cfg_data_i;
        CFG_EARLY_LIMIT:   early_q  <= cfg_data_i;
        CFG_HIGH_MARK:     high_q   <= cfg_data_i[CNT_W-1:0];
        CFG_LOW_MARK:      low_q    <= cfg_data_i[CNT_W-1:0];
        CFG_BUFFER_MIN:    bmin_q   <= cfg_data_i[BUF_W-1:0];
        CFG_BUFFER_MAX:    bmax_q   <= cfg_data_i[BUF_W-1:0];
        CFG_BUFFER_STEP:   bstep_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // queue RAMs: write tail, read at next head
  always_ff @(posedge clk_i) begin
    if (wr_en && !wr_k) mem_a[wr_addr] <= wr_data;
    if (wr_en && wr_k)  mem_v[wr_addr] <= wr_data;
    rd_q[0] <= mem_a[head_d[0]];
    rd_q[1] <= mem_v[head_d[1]];
  end

  // head view of the queue being worked on
  assign cur_k = (state_q == S_SERVE) ? k_q : op_q[0];
  assign ht    = rd_q[cur_k][ENTRY_W-1 -: TIME_W];
  assign hg    = rd_q[cur_k][TAG_W-1:0];
  assign ccnt  = cnt_q[cur_k];
  assign chead = head_q[cur_k];
  assign hinc  = (chead == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : chead + 1'b1;
  assign tsum  = (CNT_W+1)'(chead) + (CNT_W+1)'(ccnt);
  assign tail  = (tsum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                 PTR_W'(tsum - (CNT_W+1)'(QUEUE_DEPTH)) : PTR_W'(tsum);

  // latency: largest head lead over the play clock, empty queue counts zero
  always_comb begin
    logic signed [LAT_W-1:0] la, lv;
    la = (cnt_q[0] == '0) ? '0 :
         $signed({1'b0, rd_q[0][ENTRY_W-1 -: TIME_W]}) - $signed({1'b0, clk_q});
    lv = (cnt_q[1] == '0) ? '0 :
         $signed({1'b0, rd_q[1][ENTRY_W-1 -: TIME_W]}) - $signed({1'b0, clk_q});
    lat_now = (la > lv) ? la : lv;
  end

  // control sequencer
  always_comb begin
    logic [TIME_W:0]  tsat;
    logic [BUF_W:0]   bsum;
    logic [CNT_W-1:0] mx;
    state_d   = state_q;
    ret_d     = ret_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    seen_d    = seen_q;
    run_d     = run_q;
    origin_d  = origin_q;
    elapsed_d = elapsed_q;
    clk_d     = clk_q;
    buf_d     = buf_q;
    k_d       = k_q;
    pkind_d   = pkind_q;
    pev_d     = pev_q;
    ptag_d    = ptag_q;
    ptime_d   = ptime_q;
    plast_d   = plast_q;
    wr_en     = 1'b0;
    wr_k      = cur_k;
    wr_addr   = tail;
    wr_data   = {time_q, tag_q};
    oload     = 1'b0;
    tsat      = '0;
    bsum      = '0;
    mx        = (cnt_q[0] > cnt_q[1]) ? cnt_q[0] : cnt_q[1];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_UPD;
      end

      // apply the command to origin, elapsed time and run state
      S_UPD: begin
        state_d = S_CLK;
        case (op_q)
          OP_AUDIO, OP_VIDEO: begin
            if (!seen_q) begin
              seen_d    = 1'b1;
              origin_d  = time_q;
              elapsed_d = '0;
            end
          end
          OP_TICK: begin
            if (seen_q) begin
              tsat      = {1'b0, elapsed_q} + (TIME_W+1)'(adv_q);
              elapsed_d = tsat[TIME_W] ? TIME_MAX : tsat[TIME_W-1:0];
            end
          end
          OP_START: run_d = 1'b1;
          OP_STOP: begin
            if (run_q) begin
              run_d     = 1'b0;
              seen_d    = 1'b0;
              origin_d  = '0;
              elapsed_d = '0;
              head_d[0] = '0;
              head_d[1] = '0;
              cnt_d[0]  = '0;
              cnt_d[1]  = '0;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      // refresh the play clock, then branch on the command
      S_CLK: begin
        tsat  = {1'b0, origin_q} + {1'b0, elapsed_q};
        clk_d = (run_q && seen_q) ? (tsat[TIME_W] ? TIME_MAX : tsat[TIME_W-1:0]) : '0;
        ptag_d  = '0;
        ptime_d = '0;
        pkind_d = KIND_NONE;
        plast_d = 1'b1;
        if (op_q == OP_AUDIO || op_q == OP_VIDEO) begin
          state_d = S_EXP;
        end else if (op_q == OP_TICK && run_q && seen_q) begin
          k_d     = 1'b0;
          state_d = S_SERVE;
        end else begin
          pev_d   = (op_q == OP_TICK) ? EV_TICK : EV_CONTROL;
          state_d = S_EMIT;
        end
      end

      // expire stale heads, then enqueue or reject
      S_EXP: begin
        pkind_d = cur_k ? KIND_VIDEO : KIND_AUDIO;
        ret_d   = S_EXP;
        state_d = S_EMIT;
        if (ccnt != '0 &&
            ({1'b0, ht} + (TIME_W+1)'(expiry_q)) < {1'b0, time_q}) begin
          pev_d         = EV_EXPIRED;
          ptag_d        = hg;
          ptime_d       = ht;
          plast_d       = 1'b0;
          head_d[cur_k] = hinc;
          cnt_d[cur_k]  = ccnt - 1'b1;
        end else begin
          ptag_d  = tag_q;
          ptime_d = time_q;
          plast_d = 1'b1;
          if (ccnt >= CNT_W'(QUEUE_DEPTH)) begin
            pev_d = EV_REJECT;
          end else begin
            pev_d        = EV_ACCEPTED;
            wr_en        = 1'b1;
            cnt_d[cur_k] = ccnt + 1'b1;
            state_d      = S_SETTLE;
          end
        end
      end

      // let the written head reach the read register
      S_SETTLE: state_d = S_EMIT;

      // play due heads, drop heads too far ahead, audio first
      S_SERVE: begin
        pkind_d = cur_k ? KIND_VIDEO : KIND_AUDIO;
        ptag_d  = hg;
        ptime_d = ht;
        plast_d = 1'b0;
        ret_d   = S_SERVE;
        if (ccnt != '0 && (ht <= clk_q || (ht - clk_q) > TIME_W'(early_q))) begin
          pev_d         = (ht <= clk_q) ? EV_PLAY : EV_DROP;
          head_d[cur_k] = hinc;
          cnt_d[cur_k]  = ccnt - 1'b1;
          state_d       = S_EMIT;
        end else if (!k_q) begin
          k_d = 1'b1;
        end else begin
          state_d = S_ADJ;
        end
      end

      // move the buffer time by queue depth and saturate
      S_ADJ: begin
        if (mx > high_q) begin
          if ({1'b0, buf_q} < ({1'b0, bmin_q} + (BUF_W+1)'(bstep_q))) buf_d = bmin_q;
          else buf_d = buf_q - BUF_W'(bstep_q);
        end else if (mx < low_q) begin
          bsum  = {1'b0, buf_q} + (BUF_W+1)'(bstep_q);
          buf_d = (bsum > {1'b0, bmax_q}) ? bmax_q : bsum[BUF_W-1:0];
        end
        pkind_d = KIND_NONE;
        pev_d   = EV_TICK;
        ptag_d  = '0;
        ptime_d = '0;
        plast_d = 1'b1;
        state_d = S_EMIT;
      end

      // hand the pending beat to the output register
      S_EMIT: begin
        if (out_free) begin
          oload   = 1'b1;
          state_d = plast_q ? S_IDLE : ret_q;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      head_q[0] <= '0;
      head_q[1] <= '0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      seen_q    <= 1'b0;
      run_q     <= 1'b0;
      origin_q  <= '0;
      elapsed_q <= '0;
      clk_q     <= '0;
      buf_q     <= BUFFER_TIME_RST;
      k_q       <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      seen_q    <= seen_d;
      run_q     <= run_d;
      origin_q  <= origin_d;
      elapsed_q <= elapsed_d;
      clk_q     <= clk_d;
      buf_q     <= buf_d;
      k_q       <= k_d;
      if (oload)            ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // latch the accepted command and the pending beat
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_e'(opcode_i);
      time_q <= frame_time_i;
      tag_q  <= frame_tag_i;
      adv_q  <= advance_ms_i;
    end
    pkind_q <= pkind_d;
    pev_q   <= pev_d;
    ptag_q  <= ptag_d;
    ptime_q <= ptime_d;
    plast_q <= plast_d;
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (oload) begin
      okind_q <= pkind_q;
      oev_q   <= pev_q;
      otag_q  <= ptag_q;
      otime_q <= ptime_q;
      obuf_q  <= buf_q;
      olat_q  <= lat_now;
      oacnt_q <= cnt_q[0];
      ovcnt_q <= cnt_q[1];
      olast_q <= plast_q;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign stream_kind_o    = okind_q;
  assign event_code_o     = oev_q;
  assign out_tag_o        = otag_q;
  assign out_time_o       = otime_q;
  assign buffer_time_ms_o = obuf_q;
  assign latency_ms_o     = olat_q;
  assign audio_count_o    = oacnt_q;
  assign video_count_o    = ovcnt_q;
  assign last_o           = olast_q;

endmodule

/* verif/av_playout_sync_buffer_core_tb.sv */
`timescale 1ns / 100ps

module av_playout_sync_buffer_core_tb;
  import avps_pkg::*;

  localparam logic [63:0]       TIME_LIMIT     = {{(64-TIME_W){1'b0}}, {TIME_W{1'b1}}};
  localparam logic [TIME_W-1:0] TIME_TOP       = {TIME_W{1'b1}};
  localparam logic [2:0]        OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0]        OP_SPARE_LAST  = 3'd7;
  localparam int                QUIET_CYCLES   = 40;

  // Frame held in a playout queue
  typedef struct {
    logic [TIME_W-1:0] stamp;
    logic [TAG_W-1:0]  tag;
  } held_frame_t;

  // One result beat as the block should present it
  typedef struct {
    kind_e                  kind;
    event_e                 ev;
    logic [TAG_W-1:0]       tag;
    logic [TIME_W-1:0]      stamp;
    logic [BUF_W-1:0]       buffer_ms;
    logic signed [LAT_W-1:0] latency;
    logic [CNT_W-1:0]       audio_cnt;
    logic [CNT_W-1:0]       video_cnt;
    logic                   last;
  } playout_event_t;

  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_ready_o;
  logic [2:0]              opcode_i     = '0;
  logic [TIME_W-1:0]       frame_time_i = '0;
  logic [TAG_W-1:0]        frame_tag_i  = '0;
  logic [ADV_W-1:0]        advance_ms_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i  = 1'b0;
  logic [1:0]              stream_kind_o;
  logic [2:0]              event_code_o;
  logic [TAG_W-1:0]        out_tag_o;
  logic [TIME_W-1:0]       out_time_o;
  logic [BUF_W-1:0]        buffer_time_ms_o;
  logic signed [LAT_W-1:0] latency_ms_o;
  logic [CNT_W-1:0]        audio_count_o;
  logic [CNT_W-1:0]        video_count_o;
  logic                    last_o;
  logic                    cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i   = '0;

  av_playout_sync_buffer_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .frame_time_i     (frame_time_i),
    .frame_tag_i      (frame_tag_i),
    .advance_ms_i     (advance_ms_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .stream_kind_o    (stream_kind_o),
    .event_code_o     (event_code_o),
    .out_tag_o        (out_tag_o),
    .out_time_o       (out_time_o),
    .buffer_time_ms_o (buffer_time_ms_o),
    .latency_ms_o     (latency_ms_o),
    .audio_count_o    (audio_count_o),
    .video_count_o    (video_count_o),
    .last_o           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  held_frame_t      held_frames [2][$];
  logic             origin_seen = 1'b0;
  logic [63:0]      origin_ms   = '0;
  logic [63:0]      elapsed_ms  = '0;
  logic [BUF_W-1:0] buffer_ms   = BUFFER_TIME_RST;
  logic             is_running  = 1'b0;

  // Shadow of the configuration registers
  logic [15:0]      expiry_window = EXPIRY_WINDOW_RST;
  logic [15:0]      early_limit   = EARLY_LIMIT_RST;
  logic [CNT_W-1:0] high_mark     = HIGH_MARK_RST;
  logic [CNT_W-1:0] low_mark      = LOW_MARK_RST;
  logic [BUF_W-1:0] buffer_min    = BUFFER_MIN_RST;
  logic [BUF_W-1:0] buffer_max    = BUFFER_MAX_RST;
  logic [7:0]       buffer_step   = BUFFER_STEP_RST;

  playout_event_t    awaited_events[$];
  logic [TIME_W-1:0] stream_anchor = '0;
  bit                sender_idle_on   = 1'b1;
  bit                receiver_idle_on = 1'b1;
  int                stall_left       = 0;
  int                error_count      = 0;
  int                commands_sent    = 0;
  int                beats_checked    = 0;
  int                settings_applied = 1;
  int                event_tally [7];

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] error: %s", $time, msg);
  endtask

  // Play clock reads zero unless running with an origin; saturate at the top
  function automatic logic [63:0] current_play_ms();
    logic [63:0] sum;
    if (!is_running || !origin_seen) return 64'd0;
    sum = origin_ms + elapsed_ms;
    return (sum > TIME_LIMIT) ? TIME_LIMIT : sum;
  endfunction

  function automatic longint stream_lead(input int k, input logic [63:0] play_ms);
    if (held_frames[k].size() == 0) return 0;
    return longint'(64'(held_frames[k][0].stamp)) - longint'(play_ms);
  endfunction

  function automatic void log_event(input kind_e kind, input event_e ev,
                                    input logic [TAG_W-1:0] tag,
                                    input logic [TIME_W-1:0] stamp);
    playout_event_t e;
    logic [63:0]    play_ms;
    longint         la, lv;
    play_ms     = current_play_ms();
    la          = stream_lead(0, play_ms);
    lv          = stream_lead(1, play_ms);
    e.kind      = kind;
    e.ev        = ev;
    e.tag       = tag;
    e.stamp     = stamp;
    e.buffer_ms = buffer_ms;
    e.latency   = (la > lv) ? la[LAT_W-1:0] : lv[LAT_W-1:0];
    e.audio_cnt = CNT_W'(held_frames[0].size());
    e.video_cnt = CNT_W'(held_frames[1].size());
    e.last      = 1'b0;
    awaited_events.push_back(e);
  endfunction

  // Shrink or grow the buffer time by the deeper queue, then saturate
  function automatic void adjust_buffer_time();
    int deepest, b;
    deepest = (held_frames[0].size() > held_frames[1].size()) ?
              held_frames[0].size() : held_frames[1].size();
    b = int'(buffer_ms);
    if (deepest > int'(high_mark)) begin
      b -= int'(buffer_step);
      if (b < int'(buffer_min)) b = int'(buffer_min);
    end else if (deepest < int'(low_mark)) begin
      b += int'(buffer_step);
      if (b > int'(buffer_max)) b = int'(buffer_max);
    end
    buffer_ms = b[BUF_W-1:0];
  endfunction

  // Work out the result beats of one accepted command
  function automatic void predict_playout_events(input logic [2:0] op,
                                                 input logic [TIME_W-1:0] stamp,
                                                 input logic [TAG_W-1:0] tag,
                                                 input logic [ADV_W-1:0] adv);
    int          k, first;
    logic [63:0] play_ms;
    held_frame_t head;
    bit          serving;
    first = awaited_events.size();
    case (op)
      OP_AUDIO, OP_VIDEO: begin
        k = (op == OP_VIDEO) ? 1 : 0;
        if (!origin_seen) begin
          origin_seen = 1'b1;
          origin_ms   = 64'(stamp);
          elapsed_ms  = '0;
        end
        // expire stale heads before queueing
        while (held_frames[k].size() > 0 &&
               64'(held_frames[k][0].stamp) + 64'(expiry_window) < 64'(stamp)) begin
          head = held_frames[k].pop_front();
          log_event(kind_e'(k), EV_EXPIRED, head.tag, head.stamp);
        end
        if (held_frames[k].size() >= QUEUE_DEPTH) begin
          log_event(kind_e'(k), EV_REJECT, tag, stamp);
        end else begin
          head.stamp = stamp;
          head.tag   = tag;
          held_frames[k].push_back(head);
          log_event(kind_e'(k), EV_ACCEPTED, tag, stamp);
        end
      end
      OP_TICK: begin
        if (origin_seen) begin
          elapsed_ms += 64'(adv);
          if (elapsed_ms > TIME_LIMIT) elapsed_ms = TIME_LIMIT;
        end
        if (is_running && origin_seen) begin
          play_ms = current_play_ms();
          // serve audio first, then video
          for (k = 0; k < 2; k++) begin
            serving = 1'b1;
            while (serving && held_frames[k].size() > 0) begin
              head = held_frames[k][0];
              if (64'(head.stamp) <= play_ms) begin
                void'(held_frames[k].pop_front());
                log_event(kind_e'(k), EV_PLAY, head.tag, head.stamp);
              end else if (64'(head.stamp) - play_ms > 64'(early_limit)) begin
                void'(held_frames[k].pop_front());
                log_event(kind_e'(k), EV_DROP, head.tag, head.stamp);
              end else begin
                serving = 1'b0;
              end
            end
          end
          adjust_buffer_time();
        end
        log_event(KIND_NONE, EV_TICK, '0, '0);
      end
      OP_START: begin
        is_running = 1'b1;
        log_event(KIND_NONE, EV_CONTROL, '0, '0);
      end
      OP_STOP: begin
        if (is_running) begin
          is_running  = 1'b0;
          origin_seen = 1'b0;
          origin_ms   = '0;
          elapsed_ms  = '0;
          held_frames[0].delete();
          held_frames[1].delete();
        end
        log_event(KIND_NONE, EV_CONTROL, '0, '0);
      end
      default: ;
    endcase
    if (awaited_events.size() > first)
      awaited_events[awaited_events.size()-1].last = 1'b1;
  endfunction

  function automatic logic [TIME_W-1:0] random_stamp();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[TIME_W-1:0];
  endfunction

  // Pick a frame time around the play clock: waiting, too early, due or far ahead
  function automatic logic [TIME_W-1:0] pick_frame_stamp();
    logic [63:0] anchor;
    longint      offs, t;
    int          roll;
    anchor = origin_seen ? origin_ms + elapsed_ms : 64'(stream_anchor);
    if (anchor > TIME_LIMIT) anchor = TIME_LIMIT;
    roll = $urandom_range(0, 99);
    if (roll < 45)      offs = $urandom_range(0, early_limit);
    else if (roll < 60) offs = longint'(early_limit) + $urandom_range(1, 300);
    else if (roll < 85) offs = -longint'($urandom_range(0, 400));
    else                offs = longint'(expiry_window) + $urandom_range(1, 400);
    t = longint'(anchor) + offs;
    if (t < 0) t = 0;
    if (t > longint'(TIME_LIMIT)) t = longint'(TIME_LIMIT);
    return t[TIME_W-1:0];
  endfunction

  // Send one command beat, with an optional gap first
  task automatic send_command(input logic [2:0] op, input logic [TIME_W-1:0] stamp,
                              input logic [TAG_W-1:0] tag, input logic [ADV_W-1:0] adv);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    frame_time_i <= stamp;
    frame_tag_i  <= tag;
    advance_ms_i <= adv;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_playout_events(op, stamp, tag, adv);
    commands_sent++;
  endtask

  // Hold off until every result beat is in and the block has settled
  task automatic wait_for_quiet();
    in_valid_i <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_EXPIRY_WINDOW: expiry_window = data;
      CFG_EARLY_LIMIT:   early_limit   = data;
      CFG_HIGH_MARK:     high_mark     = data[CNT_W-1:0];
      CFG_LOW_MARK:      low_mark      = data[CNT_W-1:0];
      CFG_BUFFER_MIN:    buffer_min    = data[BUF_W-1:0];
      CFG_BUFFER_MAX:    buffer_max    = data[BUF_W-1:0];
      CFG_BUFFER_STEP:   buffer_step   = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_register_set(input logic [15:0] window, input logic [15:0] early,
                                    input logic [15:0] hi, input logic [15:0] lo,
                                    input logic [15:0] bmin, input logic [15:0] bmax,
                                    input logic [15:0] step);
    wait_for_quiet();
    write_register(CFG_EXPIRY_WINDOW, window);
    write_register(CFG_EARLY_LIMIT, early);
    write_register(CFG_HIGH_MARK, hi);
    write_register(CFG_LOW_MARK, lo);
    write_register(CFG_BUFFER_MIN, bmin);
    write_register(CFG_BUFFER_MAX, bmax);
    write_register(CFG_BUFFER_STEP, step);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_applied++;
  endtask

  // Controls, idle clock, play, early drop, expiry and clock saturation
  task automatic test_control_and_edges();
    int op;
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd1023);
    send_command(OP_STOP, random_stamp(), 16'($urandom()), 10'($urandom()));
    for (op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_command(3'(op), random_stamp(), 16'($urandom()), 10'($urandom()));
    send_command(OP_AUDIO, '0, 16'h0000, 10'($urandom()));
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd100);
    send_command(OP_START, random_stamp(), 16'($urandom()), 10'($urandom()));
    send_command(OP_START, random_stamp(), 16'($urandom()), 10'($urandom()));
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd0);
    send_command(OP_VIDEO, TIME_TOP, 16'hFFFF, 10'($urandom()));
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd1);
    send_command(OP_VIDEO, 48'd1200, 16'h5A5A, 10'($urandom()));
    send_command(OP_VIDEO, 48'd600, 16'hA5A5, 10'($urandom()));
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd5);
    send_command(OP_AUDIO, 48'd7000, 16'h0001, 10'($urandom()));
    send_command(OP_AUDIO, 48'd13000, 16'h8000, 10'($urandom()));
    send_command(OP_STOP, random_stamp(), 16'($urandom()), 10'($urandom()));
    send_command(OP_STOP, random_stamp(), 16'($urandom()), 10'($urandom()));
    // drive the play clock into saturation
    send_command(OP_AUDIO, TIME_TOP - 48'd1500, 16'($urandom()), 10'($urandom()));
    send_command(OP_START, random_stamp(), 16'($urandom()), 10'($urandom()));
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd1023);
    send_command(OP_VIDEO, TIME_TOP, 16'($urandom()), 10'($urandom()));
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd1023);
    send_command(OP_STOP, random_stamp(), 16'($urandom()), 10'($urandom()));
    wait_for_quiet();
  endtask

  // Fill both queues, overflow one, play them all in one tick, then mass expiry
  task automatic test_queue_limits();
    logic [TIME_W-1:0] base;
    int i;
    base = 48'd1_000_000;
    for (i = 0; i <= QUEUE_DEPTH; i++)
      send_command(OP_VIDEO, base + TIME_W'(i * 20), 16'($urandom()), 10'($urandom()));
    for (i = 0; i < QUEUE_DEPTH; i++)
      send_command(OP_AUDIO, base + TIME_W'(i * 10), 16'($urandom()), 10'($urandom()));
    send_command(OP_START, random_stamp(), 16'($urandom()), 10'($urandom()));
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd1023);
    for (i = 0; i < QUEUE_DEPTH; i++)
      send_command(OP_AUDIO, base + TIME_W'(2000 + i), 16'($urandom()), 10'($urandom()));
    send_command(OP_AUDIO, base + TIME_W'(7100), 16'($urandom()), 10'($urandom()));
    send_command(OP_TICK, random_stamp(), 16'($urandom()), 10'd0);
    send_command(OP_STOP, random_stamp(), 16'($urandom()), 10'($urandom()));
    wait_for_quiet();
  endtask

  // Mostly well-formed streams around the play clock, with noise mixed in
  task automatic test_random_traffic(input int n_items, input bit idle_allowed);
    logic [2:0]        op;
    logic [TIME_W-1:0] stamp;
    logic [TAG_W-1:0]  tag;
    logic [ADV_W-1:0]  adv;
    int                sent, roll;
    sent = 0;
    stream_anchor = ($urandom_range(0, 3) == 0) ? random_stamp() : random_stamp() >> 12;
    send_command(OP_START, random_stamp(), 16'($urandom()), 10'($urandom()));
    while (sent < n_items) begin
      if (sent % 12 == 0) begin
        sender_idle_on   = idle_allowed && ($urandom_range(0, 3) != 0);
        receiver_idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
      end
      if (idle_allowed && $urandom_range(0, 39) == 0) wait_for_quiet();
      stamp = random_stamp();
      tag   = 16'($urandom());
      adv   = 10'($urandom());
      roll  = $urandom_range(0, 99);
      if (roll < 55) begin
        op    = ($urandom_range(0, 1) == 1) ? OP_VIDEO : OP_AUDIO;
        stamp = pick_frame_stamp();
      end else if (roll < 85) begin
        op = OP_TICK;
        if ($urandom_range(0, 9) < 7) adv = 10'($urandom_range(0, 60));
      end else if (roll < 90) begin
        op = OP_START;
      end else if (roll < 93) begin
        op = OP_STOP;
      end else if (roll < 97) begin
        op = ($urandom_range(0, 1) == 1) ? OP_VIDEO : OP_AUDIO;
      end else begin
        op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
      send_command(op, stamp, tag, adv);
      if (op < OP_SPARE_FIRST) sent++;
    end
  endtask

  // Receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 16);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin : check_results
    playout_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, event_code %0d", event_code_o));
      end else begin
        want = awaited_events.pop_front();
        beats_checked++;
        event_tally[want.ev]++;
        if (stream_kind_o !== want.kind)
          report_mismatch($sformatf("stream_kind %0d, want %0d", stream_kind_o, want.kind));
        if (event_code_o !== want.ev)
          report_mismatch($sformatf("event_code %0d, want %0d", event_code_o, want.ev));
        if (out_tag_o !== want.tag)
          report_mismatch($sformatf("out_tag %0h, want %0h", out_tag_o, want.tag));
        if (out_time_o !== want.stamp)
          report_mismatch($sformatf("out_time %0h, want %0h", out_time_o, want.stamp));
        if (buffer_time_ms_o !== want.buffer_ms)
          report_mismatch($sformatf("buffer_time_ms %0d, want %0d",
                                    buffer_time_ms_o, want.buffer_ms));
        if (latency_ms_o !== want.latency)
          report_mismatch($sformatf("latency_ms %0d, want %0d", latency_ms_o, want.latency));
        if (audio_count_o !== want.audio_cnt)
          report_mismatch($sformatf("audio_count %0d, want %0d",
                                    audio_count_o, want.audio_cnt));
        if (video_count_o !== want.video_cnt)
          report_mismatch($sformatf("video_count %0d, want %0d",
                                    video_count_o, want.video_cnt));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last_o, want.last));
      end
    end
  end

  initial begin
    #16_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_control_and_edges();
    test_queue_limits();
    // extremes: no expiry slack, no early slack, widest bounds, largest step
    apply_register_set(16'd0, 16'd0, 16'd31, 16'd0, 16'd0, 16'd1023, 16'd255);
    test_random_traffic(32, 1'b1);
    // extremes the other way, with the bounds crossed
    apply_register_set(16'hFFFF, 16'hFFFF, 16'd0, 16'd31, 16'd1023, 16'd0, 16'd1);
    test_random_traffic(30, 1'b1);
    apply_register_set(16'($urandom_range(200, 2000)), 16'($urandom_range(50, 500)),
                       16'($urandom_range(2, 8)), 16'($urandom_range(1, 4)),
                       16'($urandom_range(20, 100)), 16'($urandom_range(300, 900)),
                       16'($urandom_range(1, 50)));
    test_random_traffic(32, 1'b1);
    // back to the reset values, then stream without gaps or stalls
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    apply_register_set(EXPIRY_WINDOW_RST, EARLY_LIMIT_RST, 16'(HIGH_MARK_RST),
                       16'(LOW_MARK_RST), 16'(BUFFER_MIN_RST), 16'(BUFFER_MAX_RST),
                       16'(BUFFER_STEP_RST));
    test_random_traffic(32, 1'b0);
    wait_for_quiet();
    $display("Run covered %0d commands and %0d result beats over %0d register settings.",
             commands_sent, beats_checked, settings_applied);
    $display("Events: %0d played, %0d dropped early, %0d expired, %0d rejected, %0d queued.",
             event_tally[EV_PLAY], event_tally[EV_DROP], event_tally[EV_EXPIRED],
             event_tally[EV_REJECT], event_tally[EV_ACCEPTED]);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
